>>> src/two_class_capacity_arbiter_macros.svh
// Assertion macros shared by the checker of the two-class capacity arbiter.
`ifndef TWO_CLASS_CAPACITY_ARBITER_MACROS_SVH
`define TWO_CLASS_CAPACITY_ARBITER_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define TCCA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define TCCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tcca_pkg.sv
// Types and constants for the two-class capacity arbiter.
package tcca_pkg;

	localparam int WAIT_COUNT_BITS = 16;
	localparam int WAIT_CMP_BITS   = (WAIT_COUNT_BITS > 8) ? WAIT_COUNT_BITS : 8;
	localparam int WAIT_RPT_BITS   = (WAIT_COUNT_BITS > 16) ? WAIT_COUNT_BITS : 16;

	localparam logic [7:0] CAPACITY_RESET = 8'd4;

	typedef logic [WAIT_COUNT_BITS-1:0] wait_cnt_t;

	localparam wait_cnt_t WAIT_MAX = {WAIT_COUNT_BITS{1'b1}};

	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_DEPART = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		HOLD_NONE = 2'd0,
		HOLD_A    = 2'd1,
		HOLD_B    = 2'd2
	} hold_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_EMPTY_DEP  = 2'd1,
		STATUS_WAIT_FULL  = 2'd2
	} status_t;

	localparam logic CLASS_A = 1'b0;
	localparam logic CLASS_B = 1'b1;

	typedef struct packed {
		logic opcode;
		logic requester_class;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} ev_t;

	typedef struct packed {
		logic        admitted;
		logic [7:0]  released_count;
		logic        released_class;
		logic [1:0]  active_class;
		logic [7:0]  occupancy;
		logic [15:0] waiting_a_count;
		logic [15:0] waiting_b_count;
		logic [1:0]  status;
	} rsp_t;

endpackage

>>> src/two_class_capacity_arbiter.sv
// Top level of the two-class capacity arbiter.
//
// Arbitrates a shared resource of configurable capacity between two classes
// of users, only one class holding it at a time. Each request is either an
// arrival of class A or B, or the departure of one holder, and yields exactly
// one result: whether the arrival was admitted, how many waiters the event
// released and of which class, the class now holding, the holder count and
// both waiting counts, plus a status (departure while empty, or a waiting
// counter already full, in which case the arrival is dropped). When the last
// holder leaves, a batch of up to capacity waiters is released, alternating
// classes when both wait; when a place frees with holders remaining, one
// waiter of the holding class takes it at once. One request is accepted per
// clock cycle while the output is not stalled; the result passes through the
// input register, then the result register. The rate is set by the state
// update: holder count and waiting counters are read, modified and written
// back within the same cycle through the event logic. A stalled output holds
// its result while the input register still takes one more request. Capacity
// resets to 4 and is written through cfg_wr_en / cfg_wr_data; write it only
// while no request is in flight. After reset there is no clearing pass.
module two_class_capacity_arbiter
	import tcca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic        requester_class,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        admitted,
	output logic [7:0]  released_count,
	output logic        released_class,
	output logic [1:0]  active_class,
	output logic [7:0]  occupancy,
	output logic [15:0] waiting_a_count,
	output logic [15:0] waiting_b_count,
	output logic [1:0]  status
);

	ev_t  ev_s1;
	rsp_t rsp_next;
	rsp_t rsp_q;
	logic advance;

	// Advance the held request when the result register is free or being drained.
	assign advance = ev_s1.valid && (!out_valid || out_ready);

	tcca_in_reg u_in_reg (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.requester_class (requester_class),
		.advance         (advance),
		.ev_s1           (ev_s1)
	);

	// Update arbitration state and form the result in the same cycle.
	tcca_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ev_s1       (ev_s1),
		.advance     (advance),
		.rsp_next    (rsp_next)
	);

	tcca_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.rsp_next  (rsp_next),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.rsp_q     (rsp_q)
	);

	assign admitted        = rsp_q.admitted;
	assign released_count  = rsp_q.released_count;
	assign released_class  = rsp_q.released_class;
	assign active_class    = rsp_q.active_class;
	assign occupancy       = rsp_q.occupancy;
	assign waiting_a_count = rsp_q.waiting_a_count;
	assign waiting_b_count = rsp_q.waiting_b_count;
	assign status          = rsp_q.status;

endmodule

>>> src/tcca_in_reg.sv
// Input request register of the two-class capacity arbiter.
module tcca_in_reg
	import tcca_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic opcode,
	input  logic requester_class,
	input  logic advance,
	output ev_t  ev_s1
);

	logic valid_s1;
	req_t req_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && in_ready) || (valid_s1 && !advance);
		end
	end

	// Payload: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.opcode          <= opcode;
			req_s1.requester_class <= requester_class;
		end
	end

	assign ev_s1.valid = valid_s1;
	assign ev_s1.req   = req_s1;

endmodule

>>> src/tcca_engine.sv
// Arbitration state and its combinational event update, registered on advance.
module tcca_engine
	import tcca_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  ev_t        ev_s1,
	input  logic       advance,
	output rsp_t       rsp_next
);

	logic [7:0] capacity_q;
	hold_t      hold_q, hold_n;
	logic       last_batch_q, last_batch_n;
	logic [7:0] holders_q, holders_n;
	wait_cnt_t  wait_a_q, wait_a_n;
	wait_cnt_t  wait_b_q, wait_b_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q       <= HOLD_NONE;
			last_batch_q <= CLASS_B;
			holders_q    <= '0;
			wait_a_q     <= '0;
			wait_b_q     <= '0;
		end else if (advance) begin
			hold_q       <= hold_n;
			last_batch_q <= last_batch_n;
			holders_q    <= holders_n;
			wait_a_q     <= wait_a_n;
			wait_b_q     <= wait_b_n;
		end
	end

	// Event decode
	logic                     arr_is_b;
	hold_t                    arr_hold;
	wait_cnt_t                arr_wait;
	logic                     class_ok;
	logic                     has_room;
	logic [7:0]               holders_dec;
	logic                     batch_b;
	wait_cnt_t                batch_wait;
	logic [WAIT_CMP_BITS-1:0] cap_ext;
	logic [WAIT_CMP_BITS-1:0] batch_wait_ext;
	logic [7:0]               batch_n;
	wait_cnt_t                single_wait;
	logic                     admitted;
	logic [7:0]               rel_count;
	logic                     rel_class;
	status_t                  status;
	logic [WAIT_RPT_BITS-1:0] wa_rpt;
	logic [WAIT_RPT_BITS-1:0] wb_rpt;

	always_comb begin
		arr_is_b    = ev_s1.req.requester_class;
		arr_hold    = arr_is_b ? HOLD_B : HOLD_A;
		arr_wait    = arr_is_b ? wait_b_q : wait_a_q;
		class_ok    = (hold_q == HOLD_NONE) || (hold_q == arr_hold);
		has_room    = holders_q < capacity_q;
		holders_dec = holders_q - 8'd1;

		// Batch class: alternate when both wait, else whichever waits.
		if (wait_a_q != '0 && wait_b_q != '0) begin
			batch_b = (last_batch_q == CLASS_A);
		end else begin
			batch_b = (wait_a_q == '0);
		end
		batch_wait     = batch_b ? wait_b_q : wait_a_q;
		cap_ext        = WAIT_CMP_BITS'(capacity_q);
		batch_wait_ext = WAIT_CMP_BITS'(batch_wait);
		batch_n        = (cap_ext > batch_wait_ext) ? batch_wait_ext[7:0] : capacity_q;

		single_wait = (hold_q == HOLD_B) ? wait_b_q : wait_a_q;
	end

	always_comb begin
		hold_n       = hold_q;
		last_batch_n = last_batch_q;
		holders_n    = holders_q;
		wait_a_n     = wait_a_q;
		wait_b_n     = wait_b_q;
		admitted     = 1'b0;
		rel_count    = '0;
		rel_class    = CLASS_A;
		status       = STATUS_OK;

		unique case (opcode_t'(ev_s1.req.opcode))
			OP_ARRIVE: begin
				if (class_ok && has_room && arr_wait == '0) begin
					if (hold_q == HOLD_NONE) begin
						hold_n = arr_hold;
					end
					holders_n = holders_q + 8'd1;
					admitted  = 1'b1;
				end else if (arr_wait == WAIT_MAX) begin
					status = STATUS_WAIT_FULL;
				end else if (arr_is_b) begin
					wait_b_n = wait_b_q + wait_cnt_t'(1);
				end else begin
					wait_a_n = wait_a_q + wait_cnt_t'(1);
				end
			end
			OP_DEPART: begin
				if (holders_q == '0) begin
					status = STATUS_EMPTY_DEP;
				end else if (holders_dec == '0) begin
					hold_n    = HOLD_NONE;
					holders_n = '0;
					if (wait_a_q != '0 || wait_b_q != '0) begin
						hold_n       = batch_b ? HOLD_B : HOLD_A;
						last_batch_n = batch_b;
						holders_n    = batch_n;
						rel_count    = batch_n;
						rel_class    = (batch_n != '0) ? batch_b : CLASS_A;
						if (batch_b) begin
							wait_b_n = wait_b_q - WAIT_COUNT_BITS'(batch_n);
						end else begin
							wait_a_n = wait_a_q - WAIT_COUNT_BITS'(batch_n);
						end
					end
				end else begin
					holders_n = holders_dec;
					if (holders_dec < capacity_q && (hold_q == HOLD_A || hold_q == HOLD_B)
					    && single_wait != '0) begin
						// Hand the freed place straight to one waiter.
						holders_n = holders_q;
						rel_count = 8'd1;
						rel_class = (hold_q == HOLD_B);
						if (hold_q == HOLD_B) begin
							wait_b_n = wait_b_q - wait_cnt_t'(1);
						end else begin
							wait_a_n = wait_a_q - wait_cnt_t'(1);
						end
					end
				end
			end
			default: begin
				status = STATUS_OK;
			end
		endcase

		wa_rpt = WAIT_RPT_BITS'(wait_a_n);
		wb_rpt = WAIT_RPT_BITS'(wait_b_n);

		rsp_next.admitted        = admitted;
		rsp_next.released_count  = rel_count;
		rsp_next.released_class  = rel_class;
		rsp_next.active_class    = hold_n;
		rsp_next.occupancy       = holders_n;
		rsp_next.waiting_a_count = wa_rpt[15:0];
		rsp_next.waiting_b_count = wb_rpt[15:0];
		rsp_next.status          = status;
	end

endmodule

>>> src/tcca_out_reg.sv
// Result register of the two-class capacity arbiter.
module tcca_out_reg
	import tcca_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  rsp_t rsp_next,
	input  logic out_ready,
	output logic out_valid,
	output rsp_t rsp_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

endmodule

>>> src/tcca_checker.sv
// Port-level checker for the two-class capacity arbiter, with its bind.
`include "two_class_capacity_arbiter_macros.svh"

module tcca_checker
	import tcca_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        admitted,
	input logic [7:0]  released_count,
	input logic [1:0]  active_class,
	input logic [7:0]  occupancy,
	input logic [1:0]  status
);

	`TCCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(occupancy) && $stable(status) && $stable(released_count),
		"result changed while stalled")

	`TCCA_ASSERT_IMPL(a_admit_clean, out_valid && admitted,
		status == STATUS_OK && released_count == 8'd0,
		"admitted request also released or flagged")

	`TCCA_ASSERT_IMPL(a_empty_dep, out_valid && status == STATUS_EMPTY_DEP,
		occupancy == 8'd0 && released_count == 8'd0 && !admitted,
		"empty departure changed holders")

	`TCCA_ASSERT_IMPL(a_none_empty, out_valid && active_class == HOLD_NONE,
		occupancy == 8'd0 && released_count == 8'd0,
		"holders present with no holding class")

endmodule

bind two_class_capacity_arbiter tcca_checker u_tcca_checker (.*);
